>>> rtl/bch_encode_error_trap_correct_assert.svh
// Assertion macros for the BCH(15,5) error-trapping codec.
// Used by bch_encode_error_trap_correct.sv; expects clk and rst_n in scope.
`ifndef BCH_ENCODE_ERROR_TRAP_CORRECT_ASSERT_SVH
`define BCH_ENCODE_ERROR_TRAP_CORRECT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BETC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("betc assertion failed");

// next-cycle implication
`define BETC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("betc assertion failed");

`else

`define BETC_ASSERT_IMP(lbl, ante, cons)
`define BETC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/betc_pkg.sv
// Package for the BCH(15,5) error-trapping codec: sizes, codes, reset values
// and the bit-serial division step. No dependencies.
`default_nettype none

package betc_pkg;

    localparam int CODE_LENGTH  = 15;
    localparam int MESSAGE_BITS = 5;
    localparam int PARITY_BITS  = CODE_LENGTH - MESSAGE_BITS;
    localparam int GEN_W        = PARITY_BITS + 1;
    localparam int LIMIT_W      = 4;
    localparam int DEG_W        = $clog2(GEN_W);
    localparam int WGT_W        = $clog2(CODE_LENGTH + 1);
    localparam int CNT_W        = $clog2(CODE_LENGTH + 1);
    localparam int CFG_IDX_W    = 1;
    localparam int S_TDATA_W    = ((CODE_LENGTH + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((CODE_LENGTH + MESSAGE_BITS + 7) / 8) * 8;

    localparam logic [GEN_W-1:0]   GEN_RESET   = GEN_W'(1335);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

    typedef logic [CODE_LENGTH-1:0] cw_t;
    typedef logic [GEN_W-1:0]       gen_t;
    typedef logic [PARITY_BITS-1:0] rem_t;
    typedef logic [DEG_W-1:0]       deg_t;
    typedef logic [WGT_W-1:0]       wgt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GENERATOR   = 1'b0,
        CFG_ERROR_LIMIT = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        FUNC_ENCODE  = 1'b0,
        FUNC_CORRECT = 1'b1
    } func_t;

    // index of the highest set coefficient, 0 for a zero polynomial
    function automatic deg_t poly_degree(gen_t g);
        deg_t d;
        d = '0;
        for (int i = 0; i < GEN_W; i++) begin
            if (g[i])
            begin
                d = DEG_W'(i);
            end
        end
        return d;
    endfunction

    function automatic wgt_t weight(cw_t v);
        wgt_t n;
        n = '0;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            n = n + WGT_W'(v[i]);
        end
        return n;
    endfunction

    // one LFSR division step: (x*r + b) mod g, with r below x^d
    function automatic rem_t div_step(rem_t r, logic b, gen_t g, deg_t d);
        gen_t t;
        t = {r, b};
        if (t[d])
        begin
            t = t ^ g;
        end
        return t[PARITY_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/bch_encode_error_trap_correct.sv
// BCH(15,5) systematic encoder and error-trapping corrector, top level.
// Depends on betc_pkg and bch_encode_error_trap_correct_assert.svh.
//
// One word at a time goes through a single bit-serial division unit (an
// LFSR step) and left and right one-position rotators under a small
// sequencer. Encode (tuser 0) returns msg*x^d plus its remainder mod
// the generator; correct (tuser 1) rotates the received word until the
// syndrome weight is within error_limit, XORs the syndrome in and rotates
// back, or returns the word unchanged with tuser set if no rotation traps
// the errors. The syndrome is built bit-serially, each trapping rotation
// then updates it using a stored x^15 mod g, and the rotate-back steps one
// position at a time. After reset and after every generator_poly write,
// x^15 mod g is recomputed with s_tready low; cfg writes are always
// accepted. The output register frees the core once a result is loaded,
// so the next word is accepted while the result waits.
`default_nettype none

`include "bch_encode_error_trap_correct_assert.svh"

module bch_encode_error_trap_correct
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  s_tvalid,
    output      logic                                  s_tready,
    input  wire logic [betc_pkg::S_TDATA_W-1:0]        s_tdata,   // word_in, zero pad
    input  wire logic                                  s_tuser,   // func

    output      logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    output      logic [betc_pkg::M_TDATA_W-1:0]        m_tdata,   // codeword, message, pad
    output      logic                                  m_tuser,   // uncorrectable

    input  wire logic                                  cfg_valid,
    output      logic                                  cfg_ready,
    input  wire logic [betc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [betc_pkg::GEN_W-1:0]            cfg_data
);

    localparam int CL = betc_pkg::CODE_LENGTH;
    localparam int MB = betc_pkg::MESSAGE_BITS;
    localparam int PB = betc_pkg::PARITY_BITS;
    localparam int CW = betc_pkg::CNT_W;

    typedef enum logic [6:0] {
        ST_PREP = 7'b0000001,
        ST_IDLE = 7'b0000010,
        ST_SYN  = 7'b0000100,
        ST_TRAP = 7'b0001000,
        ST_XOR  = 7'b0010000,
        ST_FIX  = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t                         state_reg,     state_next;
    logic [CW-1:0]                  cnt_reg,       cnt_next;
    betc_pkg::cw_t                  w_reg,         w_next;
    betc_pkg::rem_t                 rem_reg,       rem_next;
    betc_pkg::rem_t                 xm_reg,        xm_next;
    betc_pkg::func_t                func_reg,      func_next;
    logic                           flag_reg,      flag_next;
    betc_pkg::gen_t                 gen_reg,       gen_next;
    logic [betc_pkg::LIMIT_W-1:0]   limit_reg,     limit_next;
    logic                           out_valid_reg, out_valid_next;
    betc_pkg::cw_t                  out_cw_reg,    out_cw_next;
    logic                           out_flag_reg,  out_flag_next;

    betc_pkg::deg_t                 deg;
    logic                           gen_zero;
    betc_pkg::cw_t                  syn_full;
    logic                           trapped;
    betc_pkg::rem_t                 step_r;
    logic                           step_b;
    betc_pkg::rem_t                 step_out;
    betc_pkg::cw_t                  rot_l;
    betc_pkg::cw_t                  rot_r;
    betc_pkg::cw_t                  msg_shift;
    logic                           out_free;

    assign deg      = betc_pkg::poly_degree(gen_reg);
    assign gen_zero = (gen_reg == '0);
    // a zero generator leaves the word unreduced
    assign syn_full = gen_zero ? w_reg : {{MB{1'b0}}, rem_reg};
    assign trapped  = (betc_pkg::weight(syn_full) <= betc_pkg::WGT_W'(limit_reg));
    assign rot_l    = {w_reg[CL-2:0], w_reg[CL-1]};
    assign rot_r    = {w_reg[0], w_reg[CL-1:1]};
    assign msg_shift = CL'({{PB{1'b0}}, s_tdata[MB-1:0]} << deg);
    assign out_free = !out_valid_reg || m_tready;

    // shared division unit
    always_comb
    begin
        step_r = (state_reg == ST_PREP) ? xm_reg : rem_reg;
        unique case (state_reg)
            ST_PREP: step_b = (cnt_reg == '0);
            ST_SYN:  step_b = w_reg[cnt_reg];
            ST_TRAP: step_b = w_reg[CL-1];
            default: step_b = 1'b0;
        endcase
        step_out = betc_pkg::div_step(step_r, step_b, gen_reg, deg);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        w_next         = w_reg;
        rem_next       = rem_reg;
        xm_next        = xm_reg;
        func_next      = func_reg;
        flag_next      = flag_reg;
        gen_next       = gen_reg;
        limit_next     = limit_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_cw_next    = out_cw_reg;
        out_flag_next  = out_flag_reg;

        unique case (state_reg)
            ST_PREP:
            begin
                // x^15 mod g: feed a one, then zeros
                xm_next  = step_out;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(CL))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = betc_pkg::func_t'(s_tuser);
                    flag_next  = 1'b0;
                    rem_next   = '0;
                    cnt_next   = CW'(CL - 1);
                    w_next     = (s_tuser == betc_pkg::FUNC_CORRECT) ? s_tdata[CL-1:0]
                                                                     : msg_shift;
                    state_next = ST_SYN;
                end
            end
            ST_SYN:
            begin
                rem_next = step_out;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    cnt_next   = '0;
                    state_next = (func_reg == betc_pkg::FUNC_ENCODE) ? ST_XOR : ST_TRAP;
                end
            end
            ST_TRAP:
            begin
                if (trapped)
                begin
                    state_next = ST_XOR;
                end
                else
                begin
                    // syndrome of the rotated word, correcting for the wrapped bit
                    w_next   = rot_l;
                    rem_next = step_out ^ (w_reg[CL-1] ? xm_reg : '0);
                    if (cnt_reg == CW'(CL - 1))
                    begin
                        // a full turn brings the received word back
                        flag_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end
            ST_XOR:
            begin
                w_next     = w_reg ^ syn_full;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    w_next   = rot_r;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cw_next    = w_reg;
                    out_flag_next  = flag_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_PREP;
                cnt_next   = '0;
                xm_next    = '0;
            end
        endcase

        if (cfg_valid)
        begin
            unique case (betc_pkg::cfg_idx_t'(cfg_index))
                betc_pkg::CFG_GENERATOR:
                begin
                    gen_next   = cfg_data;
                    state_next = ST_PREP;
                    cnt_next   = '0;
                    xm_next    = '0;
                end
                betc_pkg::CFG_ERROR_LIMIT:
                begin
                    limit_next = cfg_data[betc_pkg::LIMIT_W-1:0];
                end
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_PREP;
            cnt_reg       <= '0;
            xm_reg        <= '0;
            func_reg      <= betc_pkg::FUNC_ENCODE;
            flag_reg      <= 1'b0;
            gen_reg       <= betc_pkg::GEN_RESET;
            limit_reg     <= betc_pkg::LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            xm_reg        <= xm_next;
            func_reg      <= func_next;
            flag_reg      <= flag_next;
            gen_reg       <= gen_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        rem_reg      <= rem_next;
        out_cw_reg   <= out_cw_next;
        out_flag_reg <= out_flag_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_flag_reg;
    assign m_tdata   = betc_pkg::M_TDATA_W'({out_cw_reg[CL-1:PB], out_cw_reg});

    `BETC_ASSERT_NXT(a_gen_write_blocks_input,
                     cfg_valid && cfg_ready && cfg_index == betc_pkg::CFG_GENERATOR,
                     !s_tready)
    `BETC_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `BETC_ASSERT_IMP(a_flag_only_on_correct,
                     state_reg == ST_EMIT && flag_reg,
                     func_reg == betc_pkg::FUNC_CORRECT)

endmodule

`default_nettype wire

>>> dv/bch_encode_error_trap_correct_checker.sv
// Scoreboard for the BCH(15,5) error-trapping codec: mirrors the two config
// registers, predicts each encode/correct result and compares it in order.
// Depends on betc_pkg.
module bch_encode_error_trap_correct_checker
    import betc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tready,
    input  wire logic [S_TDATA_W-1:0]    s_tdata,
    input  wire logic                    s_tuser,
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic [M_TDATA_W-1:0]    m_tdata,
    input  wire logic                    m_tuser,
    input  wire logic                    cfg_valid,
    input  wire logic                    cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [GEN_W-1:0]        cfg_data,
    output int                           errors,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        cw_t                     codeword;
        logic [MESSAGE_BITS-1:0] message;
        logic                    uncorrectable;
    } codec_result_t;

    gen_t                 gen_mirror;
    logic [LIMIT_W-1:0]   limit_mirror;
    codec_result_t        expected_q[$];
    codec_result_t        want;
    codec_result_t        got;
    int                   fail_count;

    // highest set coefficient, 0 for the zero polynomial
    function automatic int gen_order(logic [63:0] g);
        int d;
        d = 0;
        for (int i = 0; i < 64; i++) begin
            if (g[i])
            begin
                d = i;
            end
        end
        return d;
    endfunction

    function automatic logic [63:0] gf2_remainder(logic [63:0] v, logic [63:0] g);
        int d;
        if (g == '0)
        begin
            return v;
        end
        d = gen_order(g);
        for (int i = 63; i >= d; i--) begin
            if (v[i])
            begin
                v = v ^ (g << (i - d));
            end
        end
        return v;
    endfunction

    function automatic codec_result_t bch_result(func_t f, cw_t word, gen_t g,
                                                 logic [LIMIT_W-1:0] lim);
        codec_result_t r;
        logic [63:0]   shifted;
        logic [63:0]   syn;
        cw_t           w;
        cw_t           fixed;
        int            sh;
        r.uncorrectable = 1'b0;
        if (f == FUNC_ENCODE)
        begin
            sh = (g != '0) ? gen_order(64'(g)) : 0;
            shifted = 64'(word[MESSAGE_BITS-1:0]) << sh;
            r.codeword = cw_t'(shifted ^ gf2_remainder(shifted, 64'(g)));
        end
        else
        begin
            // nothing trapped: word comes back untouched with the flag set
            r.codeword = word;
            r.uncorrectable = 1'b1;
            w = word;
            for (int k = 0; k < CODE_LENGTH; k++) begin
                syn = gf2_remainder(64'(w), 64'(g));
                if ($countones(syn) <= lim)
                begin
                    fixed = w ^ cw_t'(syn);
                    repeat (k) fixed = {fixed[0], fixed[CODE_LENGTH-1:1]};
                    r.codeword = fixed;
                    r.uncorrectable = 1'b0;
                    break;
                end
                w = {w[CODE_LENGTH-2:0], w[CODE_LENGTH-1]};
            end
        end
        r.message = r.codeword[CODE_LENGTH-1 -: MESSAGE_BITS];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_mirror   <= GEN_RESET;
            limit_mirror <= LIMIT_RESET;
            expected_q.delete();
            fail_count = 0;
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.codeword      = m_tdata[CODE_LENGTH-1:0];
                got.message       = m_tdata[CODE_LENGTH +: MESSAGE_BITS];
                got.uncorrectable = m_tuser;
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word: cw %h msg %h unc %b",
                                 got.codeword, got.message, got.uncorrectable);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.codeword != want.codeword || got.message != want.message ||
                        got.uncorrectable != want.uncorrectable)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected cw %h msg %h unc %b, got cw %h msg %h unc %b",
                                     want.codeword, want.message, want.uncorrectable,
                                     got.codeword, got.message, got.uncorrectable);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(bch_result(func_t'(s_tuser), s_tdata[CODE_LENGTH-1:0],
                                                gen_mirror, limit_mirror));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_GENERATOR:   gen_mirror   <= cfg_data;
                    CFG_ERROR_LIMIT: limit_mirror <= cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            pending <= expected_q.size();
            errors  <= fail_count;
        end
    end

endmodule

>>> dv/bch_encode_error_trap_correct_tb.sv
// Top of the BCH(15,5) codec bench: clock, reset, word stimulus, config
// phases and the verdict. Depends on betc_pkg, the codec RTL and the checker.
module bch_encode_error_trap_correct_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import betc_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [GEN_W-1:0]       cfg_data  = '0;

    int   errors;
    int   pending;
    int   cycles      = 0;
    bit   quiet       = 1'b0;
    bit   hold_req    = 1'b0;
    bit   sender_gaps = 1'b0;

    bch_encode_error_trap_correct i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bch_encode_error_trap_correct_checker i_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random back-pressure, one long hold-off on request
    initial
    begin
        forever begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // multiple of g: a codeword whenever g divides x^15 - 1
    function automatic cw_t poly_mul(logic [MESSAGE_BITS-1:0] m, gen_t g);
        cw_t p;
        p = '0;
        for (int i = 0; i < MESSAGE_BITS; i++) begin
            if (m[i])
            begin
                p = p ^ (cw_t'(g) << i);
            end
        end
        return p;
    endfunction

    task automatic send_word(func_t f, cw_t word);
        if (sender_gaps && !quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= S_TDATA_W'(word);
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_config(gen_t g, logic [LIMIT_W-1:0] lim);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_GENERATOR;
        cfg_data  <= g;
        do @(posedge clk); while (!cfg_ready);
        // junk above the limit field must be dropped
        cfg_index <= CFG_ERROR_LIMIT;
        cfg_data  <= {(GEN_W-LIMIT_W)'($urandom), lim};
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(gen_t g, logic [LIMIT_W-1:0] lim, int count, bit gaps, bit hold);
        cw_t e;
        int  wgt;
        set_config(g, lim);
        sender_gaps = gaps;
        if (hold)
            hold_req = 1'b1;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1:    send_word(FUNC_ENCODE, cw_t'($urandom));
                8, 9:    send_word(FUNC_CORRECT, cw_t'($urandom));
                default:
                begin
                    e = '0;
                    wgt = $urandom_range(0, (lim < 4) ? int'(lim) + 1 : 5);
                    repeat (wgt) e[$urandom_range(0, CODE_LENGTH-1)] = 1'b1;
                    send_word(FUNC_CORRECT, poly_mul(MESSAGE_BITS'($urandom), g) ^ e);
                end
            endcase
        end
        wait_idle();
    endtask

    initial
    begin
        cw_t cw;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: message extremes, ignored high bits, trapped and
        // untrapped error patterns
        sender_gaps = 1'b1;
        cw = poly_mul(5'b10110, GEN_RESET);
        send_word(FUNC_ENCODE, 15'h0000);
        send_word(FUNC_ENCODE, 15'h001F);
        send_word(FUNC_ENCODE, 15'h0001);
        send_word(FUNC_ENCODE, 15'h0010);
        send_word(FUNC_ENCODE, 15'h7FE0);
        send_word(FUNC_ENCODE, 15'h7FFF);
        send_word(FUNC_CORRECT, 15'h0000);
        send_word(FUNC_CORRECT, 15'h7FFF);
        send_word(FUNC_CORRECT, cw);
        send_word(FUNC_CORRECT, cw ^ 15'h0001);
        send_word(FUNC_CORRECT, cw ^ 15'h4000);
        send_word(FUNC_CORRECT, cw ^ 15'h4001);
        send_word(FUNC_CORRECT, cw ^ 15'h0007);
        send_word(FUNC_CORRECT, cw ^ 15'h4201);
        send_word(FUNC_CORRECT, cw ^ 15'h1111);
        send_word(FUNC_CORRECT, 15'h0001);
        send_word(FUNC_CORRECT, 15'h5555);
        send_word(FUNC_CORRECT, 15'h2AAA);
        wait_idle();

        run_phase(GEN_RESET, 4'd0, 90, 1'b1, 1'b1);
        run_phase(GEN_RESET, 4'd3, 90, 1'b0, 1'b0);
        run_phase(gen_t'(0), 4'd10, 90, 1'b1, 1'b0);
        run_phase(gen_t'(11'h7FF), 4'd15, 90, 1'b1, 1'b0);
        run_phase(gen_t'(1), 4'd1, 90, 1'b0, 1'b0);
        run_phase(gen_t'(11'h013), 4'd2, 90, 1'b1, 1'b0);
        run_phase(gen_t'($urandom), LIMIT_W'($urandom), 90, 1'b1, 1'b0);
        run_phase(gen_t'($urandom), LIMIT_W'($urandom), 90, 1'b0, 1'b0);
        run_phase(gen_t'($urandom), LIMIT_W'($urandom), 90, 1'b1, 1'b0);
        quiet = 1'b1;
        run_phase(GEN_RESET, LIMIT_RESET, 90, 1'b0, 1'b0);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/betc_pkg.sv
rtl/bch_encode_error_trap_correct.sv
dv/bch_encode_error_trap_correct_checker.sv
dv/bch_encode_error_trap_correct_tb.sv
